@@ rtl/mbet_pkg.sv @@
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared widths, constants, register indexes and the control/status structs
// of the escape-time core.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // Fixed-point format of the complex plane (signed Q4.28)
  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM   = 4096;

  // Field and register widths
  localparam int COORD_W    = 32;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int ITER_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Mapping arithmetic: |pos * (hi - lo)| < 2^44
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = POS_W + COORD_W;
  localparam int MAP_W     = PROD_W + 2;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Iteration arithmetic: a live z component stays below 2.0 in magnitude
  localparam int Z_W   = FRAC_BITS + 2;
  localparam int ZP_W  = 2 * Z_W;
  localparam int SQ_W  = FRAC_BITS + 2;
  localparam int XY_W  = FRAC_BITS + 3;
  localparam int SUM_W = COORD_W + 2;

  localparam longint ZLIM   = 64'sd1 << (FRAC_BITS + 1);  // 2.0
  localparam longint RLIM   = 64'sd1 << (FRAC_BITS + 2);  // 4.0
  localparam longint RND_TZ = (64'sd1 << FRAC_BITS) - 1;  // round-toward-zero bias

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT     = 3'd0,
    REG_RIGHT    = 3'd1,
    REG_LOWER    = 3'd2,
    REG_UPPER    = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_ITER_CAP = 3'd6
  } cfg_reg_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // capture pixel position, clear z and count
    logic map_mul;    // form |pos * span| for the selected axis
    logic div_start;  // launch the shared divider
    logic map_store;  // add the quotient to the axis base, store c
    logic axis;       // 0: real axis, 1: imaginary axis
    logic iter_mul;   // square / cross products of z
    logic iter_add;   // escape test and z update
    logic out_load;   // move the count into the output register
  } mbet_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic cap_zero;   // iteration cap is zero
    logic iter_end;   // this update step ends the pixel
  } mbet_stat_t;

endpackage

@@ rtl/mbet_div.sv @@
// ----------------------------------------------------------------------------
// mbet_div
// Restoring unsigned divider, one quotient bit per cycle. Quotient holds
// after done until the next start.
// ----------------------------------------------------------------------------
module mbet_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mbet_pkg::PROD_W-1:0]  dividend,
  input  logic [mbet_pkg::DIM_W-1:0]   divisor,
  output logic                         busy,
  output logic                         done,
  output logic [mbet_pkg::PROD_W-1:0]  quotient
);
  import mbet_pkg::*;

  logic [PROD_W-1:0]    quo;
  logic [DIM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIM_W:0]       shifted;
  logic                 qbit;
  logic [DIM_W-1:0]     rem_next;

  // One restoring step
  always_comb begin
    shifted  = {rem, quo[PROD_W-1]};
    qbit     = (shifted >= {1'b0, divisor});
    rem_next = qbit ? DIM_W'(shifted - {1'b0, divisor}) : shifted[DIM_W-1:0];
  end

  // Step counter and handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient / remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[PROD_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/mbet_dp.sv @@
// ----------------------------------------------------------------------------
// mbet_dp
// Datapath: configuration registers, pixel-to-plane mapping with the shared
// divider, the z = z*z + c iteration registers and the output register.
// ----------------------------------------------------------------------------
module mbet_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mbet_pkg::mbet_cmd_t             cmd,
  output mbet_pkg::mbet_stat_t            stat,
  input  logic                            cfg_write,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [mbet_pkg::POS_W-1:0]      column,
  input  logic [mbet_pkg::POS_W-1:0]      row,
  output logic [mbet_pkg::ITER_W-1:0]     iterations
);
  import mbet_pkg::*;

  localparam logic signed [SUM_W-1:0] ZLIM_S = SUM_W'(ZLIM);
  localparam logic [SQ_W:0]           RLIM_U = (SQ_W + 1)'(RLIM);
  localparam logic signed [ZP_W-1:0]  RND_S  = ZP_W'(RND_TZ);
  localparam logic signed [MAP_W-1:0] C_MAX  = MAP_W'(64'sd2147483647);
  localparam logic signed [MAP_W-1:0] C_MIN  = -MAP_W'(64'sd2147483648);

  // Configuration registers
  logic signed [COORD_W-1:0] left_bound, right_bound, lower_bound, upper_bound;
  logic [DIM_W-1:0]          image_width, image_height;
  logic [ITER_W-1:0]         iter_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_bound   <= -32'sd536870912;
      right_bound  <= 32'sd536870912;
      lower_bound  <= -32'sd536870912;
      upper_bound  <= 32'sd536870912;
      image_width  <= 13'd800;
      image_height <= 13'd800;
      iter_limit   <= 16'd10000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEFT:     left_bound   <= cfg_data[COORD_W-1:0];
        REG_RIGHT:    right_bound  <= cfg_data[COORD_W-1:0];
        REG_LOWER:    lower_bound  <= cfg_data[COORD_W-1:0];
        REG_UPPER:    upper_bound  <= cfg_data[COORD_W-1:0];
        REG_WIDTH:    image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   image_height <= cfg_data[DIM_W-1:0];
        REG_ITER_CAP: iter_limit   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured pixel position
  logic [POS_W-1:0] col_q, row_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= column;
      row_q <= row;
    end
  end

  // Axis select and span product
  logic [POS_W-1:0]          sel_pos;
  logic signed [COORD_W-1:0] sel_lo, sel_hi;
  logic [DIM_W-1:0]          sel_dim_raw, sel_dim;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic [PROD_W-1:0]         prod_full;

  always_comb begin
    sel_pos     = cmd.axis ? row_q        : col_q;
    sel_lo      = cmd.axis ? lower_bound  : left_bound;
    sel_hi      = cmd.axis ? upper_bound  : right_bound;
    sel_dim_raw = cmd.axis ? image_height : image_width;
    // zero acts as one, oversize acts as the largest dimension
    if (sel_dim_raw == '0)
      sel_dim = DIM_W'(1);
    else if (sel_dim_raw > DIM_W'(MAX_DIM))
      sel_dim = DIM_W'(MAX_DIM);
    else
      sel_dim = sel_dim_raw;
    diff      = {sel_hi[COORD_W-1], sel_hi} - {sel_lo[COORD_W-1], sel_lo};
    diff_mag  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    prod_full = PROD_W'(sel_pos) * PROD_W'(diff_mag);
  end

  logic [PROD_W-1:0] prod_mag;
  logic              prod_neg;
  logic [DIM_W-1:0]  dim_q;

  always_ff @(posedge clk) begin
    if (cmd.map_mul) begin
      prod_mag <= prod_full;
      prod_neg <= diff[DIFF_W-1];
      dim_q    <= sel_dim;
    end
  end

  // Shared divider: |pos * span| / dim
  logic              div_busy, div_done;
  logic [PROD_W-1:0] quotient;

  mbet_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_mag),
    .divisor  (dim_q),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Signed quotient plus base, saturated to 32 bits
  logic signed [MAP_W-1:0]   q_s, lo_e, map_sum;
  logic signed [COORD_W-1:0] map_c;

  always_comb begin
    q_s     = prod_neg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    lo_e    = {{(MAP_W - COORD_W){sel_lo[COORD_W-1]}}, sel_lo};
    map_sum = lo_e + q_s;
    if (map_sum > C_MAX)
      map_c = C_MAX[COORD_W-1:0];
    else if (map_sum < C_MIN)
      map_c = C_MIN[COORD_W-1:0];
    else
      map_c = map_sum[COORD_W-1:0];
  end

  logic signed [COORD_W-1:0] cr, ci;

  always_ff @(posedge clk) begin
    if (cmd.map_store) begin
      if (cmd.axis)
        ci <= map_c;
      else
        cr <= map_c;
    end
  end

  // Iteration products, truncated toward zero
  logic signed [Z_W-1:0]  zr, zi;
  logic [SQ_W-1:0]        xx, yy;
  logic signed [XY_W-1:0] xy;
  logic [ITER_W-1:0]      count;
  logic signed [ZP_W-1:0] pr_rr, pr_ii, pr_ri, pr_ri_adj;

  always_comb begin
    pr_rr     = zr * zr;
    pr_ii     = zi * zi;
    pr_ri     = zr * zi;
    pr_ri_adj = pr_ri + (pr_ri[ZP_W-1] ? RND_S : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.iter_mul) begin
      xx <= pr_rr[FRAC_BITS +: SQ_W];
      yy <= pr_ii[FRAC_BITS +: SQ_W];
      xy <= pr_ri_adj[FRAC_BITS +: XY_W];
    end
  end

  // Escape tests and z update
  logic [SQ_W:0]           len;
  logic                    len_esc, range_esc, last;
  logic signed [SUM_W-1:0] xx_e, yy_e, xy_e, cr_e, ci_e, zr_new, zi_new;
  logic [ITER_W-1:0]       count_inc;

  always_comb begin
    len       = {1'b0, xx} + {1'b0, yy};
    len_esc   = (len >= RLIM_U);
    xx_e      = {{(SUM_W - SQ_W){1'b0}}, xx};
    yy_e      = {{(SUM_W - SQ_W){1'b0}}, yy};
    xy_e      = {{(SUM_W - XY_W){xy[XY_W-1]}}, xy};
    cr_e      = {{(SUM_W - COORD_W){cr[COORD_W-1]}}, cr};
    ci_e      = {{(SUM_W - COORD_W){ci[COORD_W-1]}}, ci};
    zr_new    = xx_e - yy_e + cr_e;
    zi_new    = (xy_e <<< 1) + ci_e;
    range_esc = (zr_new >= ZLIM_S) || (zr_new <= -ZLIM_S) ||
                (zi_new >= ZLIM_S) || (zi_new <= -ZLIM_S);
    count_inc = count + 1'b1;
    last      = (count_inc == iter_limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.iter_add && !len_esc) begin
      zr    <= zr_new[Z_W-1:0];
      zi    <= zi_new[Z_W-1:0];
      count <= count_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load)
      iterations <= count;
  end

  // Status back to the controller
  always_comb begin
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.cap_zero = (iter_limit == '0);
    stat.iter_end = len_esc || range_esc || last;
  end

endmodule

@@ rtl/mbet_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbet_ctrl
// Controller: sequences mapping of both axes, the iteration loop and the
// hand-off to the output register; owns the channel handshakes.
// ----------------------------------------------------------------------------
module mbet_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mbet_pkg::mbet_stat_t stat,
  output mbet_pkg::mbet_cmd_t  cmd
);
  import mbet_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_MAP_MUL   = 8'b0000_0010,
    S_DIV_GO    = 8'b0000_0100,
    S_MAP_DIV   = 8'b0000_1000,
    S_MAP_STORE = 8'b0001_0000,
    S_ITER_MUL  = 8'b0010_0000,
    S_ITER_ADD  = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   out_valid_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          axis_next  = 1'b0;
          state_next = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_MAP_DIV;
      end
      S_MAP_DIV: begin
        if (stat.div_done)
          state_next = S_MAP_STORE;
      end
      S_MAP_STORE: begin
        cmd.map_store = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_MAP_MUL;
        end else if (stat.cap_zero) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_ITER_MUL;
        end
      end
      S_ITER_MUL: begin
        cmd.iter_mul = 1'b1;
        state_next   = S_ITER_ADD;
      end
      S_ITER_ADD: begin
        cmd.iter_add = 1'b1;
        state_next   = stat.iter_end ? S_FINISH : S_ITER_MUL;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.out_load)
      out_valid_next = 1'b1;
    else if (out_ready)
      out_valid_next = 1'b0;
    else
      out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/mandelbrot_escape_time_core.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time evaluator for one pixel of a Mandelbrot image.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one pixel request: column, row.
// The pixel is mapped onto the plane window set by the bound registers
// (signed Q4.28), then z = z*z + c is iterated from zero until |z| reaches 2
// or the count hits the iteration cap. The output channel (out_valid/out_ready)
// returns that count in iterations, one result per request, in order.
// Each axis mapping runs the shared 44-step restoring divider, and each
// iteration is one multiply step plus one add/test step. One request is
// worked at a time; the next is accepted as soon as the current result
// sits in the output register, so a stalled receiver holds up at most one
// finished result before the core waits in its finish step.
// Configuration: cfg_write/cfg_index/cfg_data, one register per cycle, while
// no request is in flight. Reset (rst, synchronous) restores the default
// window of +/-2.0, an 800x800 image and an iteration cap of 10000, and
// empties both channels.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mbet_pkg::POS_W-1:0]      column,
  input  logic [mbet_pkg::POS_W-1:0]      row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mbet_pkg::ITER_W-1:0]     iterations,
  input  logic                            cfg_write,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbet_pkg::*;

  mbet_cmd_t  cmd;
  mbet_stat_t stat;

  // Sequencer
  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and registers
  mbet_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .column     (column),
    .row        (row),
    .iterations (iterations)
  );

`ifndef ASSERT_OFF
  // Datapath steps never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.map_mul, cmd.div_start, cmd.map_store,
              cmd.iter_mul, cmd.iter_add, cmd.out_load}))
    else $error("overlapping datapath commands");

  // Divider is only launched when idle
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // An accepted request blocks further requests
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while busy");

  // Loading the output register raises valid
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded without valid");
`endif

endmodule

@@ tb/mandelbrot_escape_time_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core_tb
// Self-checking bench for the escape-time core. Every accepted pixel request
// is run through a local fixed-point model of the mapping and iteration. The
// result is queued and compared in order with the counts that the core
// returns. Directed windows cover the corners first, then randomized windows
// and random pacing on both channels. One long receiver stall backs up the
// core.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core_tb;
  import mbet_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind it
  localparam longint TWO_Q  = 64'sd2 <<< FRAC_BITS;
  localparam longint FOUR_Q = 64'sd4 <<< FRAC_BITS;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // Ordered store of expected iteration counts
  class escape_count_tracker;
    logic [ITER_W-1:0] awaited_counts[$];
    int errors;

    function void note_request(logic [ITER_W-1:0] count);
      awaited_counts.push_back(count);
    endfunction

    function void check_result(logic [ITER_W-1:0] got);
      logic [ITER_W-1:0] want;
      if (awaited_counts.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = awaited_counts.pop_front();
      if (got !== want) begin
        $display("%0t: iterations mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [POS_W-1:0]      column;
  logic [POS_W-1:0]      row;
  logic                  out_valid;
  logic                  out_ready;
  logic [ITER_W-1:0]     iterations;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Local copy of the register file
  logic [31:0]       win_left, win_right, win_lower, win_upper;
  logic [DIM_W-1:0]  win_width, win_height;
  logic [ITER_W-1:0] iter_cap;

  escape_count_tracker tracker;
  int unsigned cycle_count;
  bit tx_calm, rx_calm;
  bit hold_request;
  int hold_left, stall_left;

  mandelbrot_escape_time_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .column     (column),
    .row        (row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iterations (iterations),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model
  // ---------------------------------------------------------------------------
  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return longint'(s[63:0]);
  endfunction

  // (a*b) >> FRAC_BITS, truncated toward zero
  function automatic longint fix_mul(longint a, longint b);
    logic signed [127:0] prod;
    logic [127:0] mag_p;
    logic [127:0] shifted;
    prod = $signed(128'(a)) * $signed(128'(b));
    mag_p = (prod < 0) ? -prod : prod;
    shifted = mag_p >> FRAC_BITS;
    if (shifted > 128'(I64_MAX)) shifted = 128'(I64_MAX);
    return (prod < 0) ? -longint'(shifted[63:0]) : longint'(shifted[63:0]);
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // zero acts as one, anything past MAX_DIM as MAX_DIM
  function automatic int eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic longint map_axis(logic [POS_W-1:0] pos, logic [31:0] lo_r,
                                      logic [31:0] hi_r, logic [DIM_W-1:0] dim_r);
    longint lo, hi, p, d, v;
    lo = $signed(lo_r);
    hi = $signed(hi_r);
    p = pos;
    d = eff_dim(dim_r);
    v = lo + (p * (hi - lo)) / d;
    if (v > I32_MAX) v = I32_MAX;
    if (v < I32_MIN) v = I32_MIN;
    return v;
  endfunction

  function automatic logic [ITER_W-1:0] escape_count(logic [POS_W-1:0] col,
                                                     logic [POS_W-1:0] rw);
    longint cr, ci, zr, zi, xx, yy, xy, len;
    int n;
    bit gone;
    cr = map_axis(col, win_left, win_right, win_width);
    ci = map_axis(rw, win_lower, win_upper, win_height);
    zr = 0;
    zi = 0;
    n = 0;
    gone = 1'b0;
    while (n < int'(iter_cap) && !gone) begin
      xx = fix_mul(zr, zr);
      yy = fix_mul(zi, zi);
      xy = fix_mul(zr, zi);
      zr = sat_sum(sat_sum(xx, -yy), cr);
      zi = sat_sum(sat_sum(xy, xy), ci);
      n++;
      // a large component escapes without forming |z|^2
      if (magnitude(zr) >= 64'(TWO_Q) || magnitude(zi) >= 64'(TWO_Q)) begin
        gone = 1'b1;
      end else begin
        len = sat_sum(fix_mul(zr, zr), fix_mul(zi, zi));
        gone = (len >= FOUR_Q);
      end
    end
    return n[ITER_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
    if (r < 4) return DIM_W'(MAX_DIM);
    return DIM_W'($urandom_range(1, MAX_DIM));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LEFT:     win_left   = data;
      REG_RIGHT:    win_right  = data;
      REG_LOWER:    win_lower  = data;
      REG_UPPER:    win_upper  = data;
      REG_WIDTH:    win_width  = data[DIM_W-1:0];
      REG_HEIGHT:   win_height = data[DIM_W-1:0];
      REG_ITER_CAP: iter_cap   = data[ITER_W-1:0];
      default: ;
    endcase
  endtask

  // full register set; narrow registers get junk in their unused bits
  task automatic set_window(input logic [31:0] l, input logic [31:0] r,
                            input logic [31:0] lo, input logic [31:0] up,
                            input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [ITER_W-1:0] cap);
    logic [31:0] junk;
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, up);
    junk = $urandom();
    write_reg(REG_WIDTH, {junk[31:DIM_W], w});
    junk = $urandom();
    write_reg(REG_HEIGHT, {junk[31:DIM_W], h});
    junk = $urandom();
    write_reg(REG_ITER_CAP, {junk[31:ITER_W], cap});
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  task automatic send_pixel(input logic [POS_W-1:0] col, input logic [POS_W-1:0] rw);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    column   <= col;
    row      <= rw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(escape_count(col, rw));
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // core is idle once the last count is back
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (tracker.awaited_counts.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing, result check, watchdog
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 2000;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(iterations);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time,
               tracker.awaited_counts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    longint ctr_r, ctr_i, half_r, half_i;
    logic [31:0] b0, b1, b2, b3;
    logic [DIM_W-1:0] w, h;
    logic [ITER_W-1:0] cap;
    logic [POS_W-1:0] col, rw;
    int sh;

    tracker = new();
    cycle_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    column = '0;
    row = '0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_LEFT;
    cfg_data = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    stall_left = 0;
    // reset values of the register file
    win_left   = 32'hE000_0000;
    win_right  = 32'h2000_0000;
    win_lower  = 32'hE000_0000;
    win_upper  = 32'h2000_0000;
    win_width  = 13'd800;
    win_height = 13'd800;
    iter_cap   = 16'd10000;

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // default window: corners, the origin, positions past the image
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd799, 12'd799);
    send_pixel(12'd400, 12'd400);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();

    // widest window, reversed on the imaginary axis, zero width, oversized height, top cap
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               13'd0, 13'd8191, 16'hFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd2048);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2048, 12'd1);
    drain();

    // c = 0 everywhere: runs to the full cap
    set_window(32'h0, 32'h0, 32'h0, 32'h0, 13'd1, 13'd1, 16'hFFFF);
    send_pixel(12'd5, 12'd7);
    drain();

    // write to an unused index, then a zero cap
    write_reg(REG_SPARE, $urandom());
    write_reg(REG_ITER_CAP, {16'hA5C3, 16'd0});
    @(negedge clk) cfg_write <= 1'b0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // 16x16 grid over [-2,2]: escape on a large component, escape on |z|^2,
    // bounded points, a two-step escape
    set_window(32'hE000_0000, 32'h2000_0000, 32'hE000_0000, 32'h2000_0000,
               13'd16, 13'd16, 16'd200);
    send_pixel(12'd0, 12'd8);
    send_pixel(12'd8, 12'd8);
    send_pixel(12'd15, 12'd15);
    send_pixel(12'd4, 12'd8);
    send_pixel(12'd12, 12'd4);
    send_pixel(12'd7, 12'd6);
    drain();

    // random windows, mostly zoomed near the set
    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 9) < 7) begin
        ctr_r = longint'($urandom_range(0, 805306368)) - 64'sd590558003;
        ctr_i = longint'($urandom_range(0, 644245094)) - 64'sd322122547;
        sh = $urandom_range(10, 29);
        half_r = $urandom_range(1 << (sh - 1), 1 << sh);
        half_i = half_r >> $urandom_range(0, 2);
        b0 = 32'(ctr_r - half_r);
        b1 = 32'(ctr_r + half_r);
        b2 = 32'(ctr_i - half_i);
        b3 = 32'(ctr_i + half_i);
      end else begin
        b0 = $urandom();
        b1 = $urandom();
        b2 = $urandom();
        b3 = $urandom();
      end
      w = pick_dim();
      h = pick_dim();
      cap = ($urandom_range(0, 9) < 8) ? ITER_W'($urandom_range(1, 300))
                                       : ITER_W'($urandom_range(301, 1000));
      set_window(b0, b1, b2, b3, w, h, cap);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 20; k++) begin
        // long receiver hold while requests keep coming
        if (p == 1 && k == 3) hold_request = 1'b1;
        col = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, eff_dim(win_width) - 1))
                                           : POS_W'($urandom_range(0, 4095));
        rw = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, eff_dim(win_height) - 1))
                                          : POS_W'($urandom_range(0, 4095));
        send_pixel(col, rw);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (tracker.awaited_counts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.awaited_counts.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
